FILE: src/lzwd_pkg.sv
package lzwd_pkg;

   localparam int MAX_CODE_BITS = 16;
   localparam int STACK_DEPTH   = 63;
   localparam int SP_W          = $clog2(STACK_DEPTH + 1);
   localparam int DICT_DEPTH    = 65536;
   localparam int DICT_AW       = $clog2(DICT_DEPTH);

   typedef logic [2:0] status_type;
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_END      = 3'd1;
   localparam status_type ST_MAGIC    = 3'd2;
   localparam status_type ST_WIDTH    = 3'd3;
   localparam status_type ST_OVERFLOW = 3'd4;

   localparam logic [7:0] MAGIC_0 = 8'h1f;
   localparam logic [7:0] MAGIC_1 = 8'h9d;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_end;
      status_type status;
   } rsp_type;

endpackage

FILE: src/lzw_stream_decompressor_top.sv
// Decompressor for the classic .Z stream: one compressed byte per request, header
// included. Each request is latched in the idle state and then parsed; a byte that
// completes a code walks the dictionary chain entry by entry (dictionary memory read,
// then stack push) and replays the string from the character stack byte by byte
// (stack memory read, then emit, which waits while the output buffer is full). The
// dictionary (64K x 24) and stack memories are the limit. Results go through a
// 2-entry output buffer, so a stalled result side holds the block only when it fills.
// After an error or end of stream every later request is taken and dropped until reset.
module lzw_stream_decompressor_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_end,
   output logic [2:0] rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_PARSE, S_DEC, S_WALK, S_PUSH, S_UPDATE,
      S_POP, S_EMIT, S_REGROUP, S_STATUS, S_HALT
   } state_type;

   localparam int SP_W = lzwd_pkg::SP_W;

   state_type                 state_ff, state_in;
   logic [1:0]                header_pos_ff, header_pos_in;
   logic [4:0]                width_limit_ff, width_limit_in;
   logic                      block_mode_ff, block_mode_in;
   logic [4:0]                code_width_ff, code_width_in;
   logic [16:0]               width_ceiling_ff, width_ceiling_in;
   logic [16:0]               next_free_ff, next_free_in;
   logic [23:0]               bit_accum_ff, bit_accum_in;
   logic [4:0]                bits_held_ff, bits_held_in;
   logic [4:0]                group_count_ff, group_count_in;
   logic                      discard_ff, discard_in;
   logic                      clear_seen_ff, clear_seen_in;
   logic [15:0]               prev_code_ff, prev_code_in;
   logic [7:0]                prev_first_ff, prev_first_in;
   logic                      first_done_ff, first_done_in;
   logic [7:0]                byte_ff, byte_in;
   logic                      last_ff, last_in;
   logic [15:0]               code_ff, code_in;
   logic [15:0]               cur_ff, cur_in;
   logic [15:0]               incode_ff, incode_in;
   logic [SP_W-1:0]           sp_ff, sp_in;
   logic [7:0]                fin_ff, fin_in;
   lzwd_pkg::status_type      status_ff, status_in;

   logic                      push, full;
   lzwd_pkg::rsp_type         push_data;
   logic                      dict_rd_en, dict_wr_en;
   logic [23:0]               dict_rd_data;
   logic                      stk_wr_en, stk_rd_en;
   logic [SP_W-1:0]           stk_wr_addr;
   logic [7:0]                stk_wr_data, stk_rd_data;

   logic [23:0] acc;
   logic [4:0]  bits, grp, gdec, cw_new;
   logic [16:0] mask;
   logic        grow;

   always_comb begin
      state_in         = state_ff;
      header_pos_in    = header_pos_ff;
      width_limit_in   = width_limit_ff;
      block_mode_in    = block_mode_ff;
      code_width_in    = code_width_ff;
      width_ceiling_in = width_ceiling_ff;
      next_free_in     = next_free_ff;
      bit_accum_in     = bit_accum_ff;
      bits_held_in     = bits_held_ff;
      group_count_in   = group_count_ff;
      discard_in       = discard_ff;
      clear_seen_in    = clear_seen_ff;
      prev_code_in     = prev_code_ff;
      prev_first_in    = prev_first_ff;
      first_done_in    = first_done_ff;
      byte_in          = byte_ff;
      last_in          = last_ff;
      code_in          = code_ff;
      cur_in           = cur_ff;
      incode_in        = incode_ff;
      sp_in            = sp_ff;
      fin_in           = fin_ff;
      status_in        = status_ff;
      req_stall        = 1'b1;
      push             = 1'b0;
      push_data        = '0;
      dict_rd_en       = 1'b0;
      dict_wr_en       = 1'b0;
      stk_wr_en        = 1'b0;
      stk_wr_addr      = sp_ff;
      stk_wr_data      = '0;
      stk_rd_en        = 1'b0;

      acc    = bit_accum_ff | ({16'd0, byte_ff} << bits_held_ff[3:0]);
      bits   = bits_held_ff + 5'd8;
      grp    = group_count_ff + 5'd1;
      gdec   = (group_count_ff != 5'd0) ? group_count_ff - 5'd1 : 5'd0;
      mask   = (17'd1 << code_width_ff) - 17'd1;
      grow   = next_free_ff > width_ceiling_ff;
      cw_new = (code_width_ff < 5'd16) ? code_width_ff + 5'd1 : code_width_ff;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               byte_in  = req_data_byte;
               last_in  = req_last_byte;
               state_in = S_PARSE;
            end
         end
         S_PARSE: begin
            status_in = lzwd_pkg::ST_END;
            state_in  = last_ff ? S_STATUS : S_IDLE;
            if (header_pos_ff == 2'd0) begin
               if (byte_ff != lzwd_pkg::MAGIC_0) begin
                  status_in = lzwd_pkg::ST_MAGIC;
                  state_in  = S_STATUS;
               end else begin
                  header_pos_in = 2'd1;
               end
            end else if (header_pos_ff == 2'd1) begin
               if (byte_ff != lzwd_pkg::MAGIC_1) begin
                  status_in = lzwd_pkg::ST_MAGIC;
                  state_in  = S_STATUS;
               end else begin
                  header_pos_in = 2'd2;
               end
            end else if (header_pos_ff == 2'd2) begin
               width_limit_in = byte_ff[4:0];
               block_mode_in  = byte_ff[7];
               if (byte_ff[4:0] > 5'(lzwd_pkg::MAX_CODE_BITS)) begin
                  status_in = lzwd_pkg::ST_WIDTH;
                  state_in  = S_STATUS;
               end else begin
                  header_pos_in    = 2'd3;
                  code_width_in    = 5'd9;
                  width_ceiling_in = 17'd511;
                  next_free_in     = byte_ff[7] ? 17'd257 : 17'd256;
               end
            end else if (discard_ff) begin
               group_count_in = gdec;
               if (gdec == 5'd0) discard_in = 1'b0;
            end else begin
               bit_accum_in   = acc;
               bits_held_in   = bits;
               group_count_in = grp;
               if (bits >= code_width_ff) begin
                  code_in      = acc[15:0] & mask[15:0];
                  bit_accum_in = acc >> code_width_ff;
                  bits_held_in = bits - code_width_ff;
                  state_in     = S_DEC;
               end
               if (grp >= code_width_ff) begin
                  group_count_in = 5'd0;
                  bit_accum_in   = '0;
                  bits_held_in   = 5'd0;
               end
            end
         end
         S_DEC: begin
            if (!first_done_ff) begin
               if (!full) begin
                  push               = 1'b1;
                  push_data.out_byte = code_ff[7:0];
                  push_data.has_byte = 1'b1;
                  push_data.run_end  = !last_ff;
                  push_data.status   = lzwd_pkg::ST_OK;
                  first_done_in      = 1'b1;
                  prev_code_in       = code_ff;
                  prev_first_in      = code_ff[7:0];
                  state_in           = S_REGROUP;
               end
            end else if (block_mode_ff && code_ff == 16'd256 && !clear_seen_ff) begin
               next_free_in  = 17'd256;
               clear_seen_in = 1'b1;
               state_in      = S_REGROUP;
            end else begin
               clear_seen_in = 1'b0;
               incode_in     = code_ff;
               // KwKwK: code not yet in the table
               if ({1'b0, code_ff} >= next_free_ff) begin
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = '0;
                  stk_wr_data = prev_first_ff;
                  sp_in       = SP_W'(1);
                  cur_in      = prev_code_ff;
               end else begin
                  sp_in  = '0;
                  cur_in = code_ff;
               end
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sp_ff >= SP_W'(lzwd_pkg::STACK_DEPTH)) begin
               status_in = lzwd_pkg::ST_OVERFLOW;
               state_in  = S_STATUS;
            end else if (cur_ff >= 16'd256) begin
               dict_rd_en = 1'b1;
               state_in   = S_PUSH;
            end else begin
               stk_wr_en   = 1'b1;
               stk_wr_data = cur_ff[7:0];
               sp_in       = sp_ff + SP_W'(1);
               fin_in      = cur_ff[7:0];
               state_in    = S_UPDATE;
            end
         end
         S_PUSH: begin
            stk_wr_en   = 1'b1;
            stk_wr_data = dict_rd_data[7:0];
            sp_in       = sp_ff + SP_W'(1);
            cur_in      = dict_rd_data[23:8];
            state_in    = S_WALK;
         end
         S_UPDATE: begin
            if (next_free_ff < (17'd1 << width_limit_ff) && next_free_ff < 17'h10000) begin
               dict_wr_en   = 1'b1;
               next_free_in = next_free_ff + 17'd1;
            end
            prev_code_in  = incode_ff;
            prev_first_in = fin_ff;
            state_in      = S_POP;
         end
         S_POP: begin
            stk_rd_en = 1'b1;
            sp_in     = sp_ff - SP_W'(1);
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!full) begin
               push               = 1'b1;
               push_data.out_byte = stk_rd_data;
               push_data.has_byte = 1'b1;
               push_data.run_end  = (sp_ff == '0) && !last_ff;
               push_data.status   = lzwd_pkg::ST_OK;
               state_in           = (sp_ff == '0) ? S_REGROUP : S_POP;
            end
         end
         S_REGROUP: begin
            if (grow || clear_seen_ff) begin
               if (grow) begin
                  code_width_in = cw_new;
                  if (cw_new == width_limit_ff) width_ceiling_in = 17'd1 << width_limit_ff;
                  else width_ceiling_in = (17'd1 << cw_new) - 17'd1;
               end
               if (clear_seen_ff) begin
                  code_width_in    = 5'd9;
                  width_ceiling_in = 17'd511;
               end
               bit_accum_in = '0;
               bits_held_in = 5'd0;
               // skip the unread rest of the current group
               if (group_count_ff != 5'd0 && code_width_ff > group_count_ff) begin
                  group_count_in = code_width_ff - group_count_ff;
                  discard_in     = 1'b1;
               end else begin
                  group_count_in = 5'd0;
               end
            end
            status_in = lzwd_pkg::ST_END;
            state_in  = last_ff ? S_STATUS : S_IDLE;
         end
         S_STATUS: begin
            if (!full) begin
               push              = 1'b1;
               push_data.run_end = 1'b1;
               push_data.status  = status_ff;
               state_in          = S_HALT;
            end
         end
         S_HALT: begin
            req_stall = 1'b0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         header_pos_ff    <= 2'd0;
         width_limit_ff   <= 5'(lzwd_pkg::MAX_CODE_BITS);
         block_mode_ff    <= 1'b1;
         code_width_ff    <= 5'd9;
         width_ceiling_ff <= 17'd511;
         next_free_ff     <= 17'd257;
         bit_accum_ff     <= '0;
         bits_held_ff     <= 5'd0;
         group_count_ff   <= 5'd0;
         discard_ff       <= 1'b0;
         clear_seen_ff    <= 1'b0;
         prev_code_ff     <= '0;
         prev_first_ff    <= '0;
         first_done_ff    <= 1'b0;
         sp_ff            <= '0;
         status_ff        <= lzwd_pkg::ST_OK;
      end else begin
         state_ff         <= state_in;
         header_pos_ff    <= header_pos_in;
         width_limit_ff   <= width_limit_in;
         block_mode_ff    <= block_mode_in;
         code_width_ff    <= code_width_in;
         width_ceiling_ff <= width_ceiling_in;
         next_free_ff     <= next_free_in;
         bit_accum_ff     <= bit_accum_in;
         bits_held_ff     <= bits_held_in;
         group_count_ff   <= group_count_in;
         discard_ff       <= discard_in;
         clear_seen_ff    <= clear_seen_in;
         prev_code_ff     <= prev_code_in;
         prev_first_ff    <= prev_first_in;
         first_done_ff    <= first_done_in;
         sp_ff            <= sp_in;
         status_ff        <= status_in;
      end
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      code_ff   <= code_in;
      cur_ff    <= cur_in;
      incode_ff <= incode_in;
      fin_ff    <= fin_in;
   end

   lzwd_ram #(.WIDTH(24), .DEPTH(lzwd_pkg::DICT_DEPTH)) u_dict (
      .clock      (clock),
      .wr_en      (dict_wr_en),
      .wr_addr    (next_free_ff[lzwd_pkg::DICT_AW-1:0]),
      .wr_data    ({prev_code_ff, fin_ff}),
      .rd_en      (dict_rd_en),
      .rd_addr    (cur_ff),
      .rd_data_ff (dict_rd_data)
   );

   lzwd_ram #(.WIDTH(8), .DEPTH(1 << SP_W)) u_stack (
      .clock      (clock),
      .wr_en      (stk_wr_en),
      .wr_addr    (stk_wr_addr),
      .wr_data    (stk_wr_data),
      .rd_en      (stk_rd_en),
      .rd_addr    (sp_ff - SP_W'(1)),
      .rd_data_ff (stk_rd_data)
   );

   lzwd_out_buf u_out (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data    (push_data),
      .full         (full),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_run_end  (rsp_run_end),
      .rsp_status   (rsp_status)
   );

endmodule

FILE: src/lzwd_ram.sv
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: src/lzwd_out_buf.sv
module lzwd_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lzwd_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_run_end,
   output logic [2:0]       rsp_status
);

   lzwd_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign rsp_valid    = (count_ff != 2'd0);
   assign full         = (count_ff == 2'd2);
   assign pop          = rsp_valid && !rsp_stall;
   assign rsp_out_byte = entry_ff[rd_ptr_ff].out_byte;
   assign rsp_has_byte = entry_ff[rd_ptr_ff].has_byte;
   assign rsp_run_end  = entry_ff[rd_ptr_ff].run_end;
   assign rsp_status   = entry_ff[rd_ptr_ff].status;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
